### design/spsm_pkg.sv
// types and constants shared by the scrolling plot sample mapper
`timescale 1ns / 1ps
`default_nettype none
package spsm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int REG_W      = 11;
  localparam int ROW_W      = 16;
  localparam int IDX_W      = 10;
  localparam int FRAC_W     = 4;
  localparam int HMAG_W     = 11;
  localparam int PROD_W     = SAMPLE_W + HMAG_W;
  localparam int NUM_W      = PROD_W + FRAC_W;
  // quotient stays below (2^HMAG_W)*16 because the difference is below the span
  localparam int QUOT_W     = HMAG_W + FRAC_W;
  localparam int STEP_W     = $clog2(QUOT_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [SAMPLE_W-1:0] Y_MIN_RST   = 32'sd0;
  localparam logic [SAMPLE_W-1:0] Y_MAX_RST   = 32'sd255;
  localparam logic [REG_W-1:0]    BUF_LEN_RST = 11'd1024;

  typedef enum logic [2:0] {
    REG_Y_MIN         = 3'd0,
    REG_Y_MAX         = 3'd1,
    REG_TOP_ROW       = 3'd2,
    REG_PLOT_HEIGHT   = 3'd3,
    REG_PLOT_WIDTH    = 3'd4,
    REG_BUFFER_LENGTH = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_TOP    = 2'd0,
    KIND_BOTTOM = 2'd1,
    KIND_DIVIDE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_MUL  = 2'd1,
    B_DIV  = 2'd2,
    B_DONE = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y_min;
    logic [SAMPLE_W-1:0] y_max;
    logic [REG_W-1:0]    top_row;
    logic [REG_W-1:0]    plot_height;
    logic [REG_W-1:0]    plot_width;
    logic [REG_W-1:0]    buffer_length;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] diff;
    logic [ROW_W-1:0]    row_q4;
    logic [IDX_W-1:0]    write_index;
    logic [IDX_W-1:0]    window_end_index;
  } entry_t;

endpackage
`default_nettype wire

### design/spsm_if.sv
// word channels of the scrolling plot sample mapper
`timescale 1ns / 1ps
`default_nettype none
interface spsm_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [spsm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface spsm_out_if;
  logic                          valid;
  logic                          ready;
  logic [spsm_pkg::ROW_W-1:0]    row_q4;
  logic [spsm_pkg::IDX_W-1:0]    write_index;
  logic [spsm_pkg::IDX_W-1:0]    window_end_index;

  modport source (output valid, output row_q4, output write_index,
                  output window_end_index, input ready);
  modport sink (input valid, input row_q4, input write_index,
                input window_end_index, output ready);
endinterface
`default_nettype wire

### design/spsm_front.sv
// front end: takes samples, sorts them into clamp or divide, steps the ring pointers
`timescale 1ns / 1ps
`default_nettype none
module spsm_front #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spsm_pkg::cfg_t cfg,
  spsm_in_if.sink             in_ch,
  input  wire logic           q_full,
  output logic                push,
  output spsm_pkg::entry_t    push_entry
);

  localparam int PTR_W   = $clog2(BUFFER_DEPTH);
  localparam int LEN_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W   = (LEN_W > spsm_pkg::REG_W) ? LEN_W : spsm_pkg::REG_W;
  localparam int RST_LEN = (int'(spsm_pkg::BUF_LEN_RST) < BUFFER_DEPTH) ?
                           int'(spsm_pkg::BUF_LEN_RST) : BUFFER_DEPTH;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] we_r, we_nxt;
  logic [PTR_W-1:0] last;
  logic [CMP_W-1:0] len_ext;
  logic             accept;
  logic             enabled;
  logic [spsm_pkg::REG_W:0] top_sum;
  logic [spsm_pkg::REG_W:0] bot_sum;

  // effective last entry, length saturated to 1..depth
  always_comb begin
    len_ext = CMP_W'(cfg.buffer_length);
    if (len_ext == '0) begin
      last = '0;
    end else if (len_ext > CMP_W'(BUFFER_DEPTH)) begin
      last = PTR_W'(BUFFER_DEPTH - 1);
    end else begin
      last = PTR_W'(len_ext - CMP_W'(1));
    end
  end

  assign enabled     = (cfg.plot_height != '0) && (cfg.plot_width != '0);
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && enabled;

  assign wp_nxt = (wp_r >= last) ? '0 : wp_r + PTR_W'(1);
  assign we_nxt = (we_r >= last) ? '0 : we_r + PTR_W'(1);

  assign top_sum = (spsm_pkg::REG_W + 1)'(cfg.top_row) + (spsm_pkg::REG_W + 1)'(1);
  assign bot_sum = (spsm_pkg::REG_W + 1)'(cfg.top_row)
                 + (spsm_pkg::REG_W + 1)'(cfg.plot_height)
                 - (spsm_pkg::REG_W + 1)'(1);

  always_comb begin
    push_entry.diff             = in_ch.sample - cfg.y_min;
    push_entry.write_index      = spsm_pkg::IDX_W'(wp_r);
    push_entry.window_end_index = spsm_pkg::IDX_W'(we_nxt);
    if ($signed(in_ch.sample) >= $signed(cfg.y_max)) begin
      push_entry.kind   = spsm_pkg::KIND_TOP;
      push_entry.row_q4 = {top_sum, {spsm_pkg::FRAC_W{1'b0}}};
    end else if ($signed(in_ch.sample) <= $signed(cfg.y_min)) begin
      push_entry.kind   = spsm_pkg::KIND_BOTTOM;
      push_entry.row_q4 = {bot_sum, {spsm_pkg::FRAC_W{1'b0}}};
    end else begin
      // bottom row is the base the back end offsets from
      push_entry.kind   = spsm_pkg::KIND_DIVIDE;
      push_entry.row_q4 = {bot_sum, {spsm_pkg::FRAC_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      we_r <= PTR_W'(RST_LEN - 1);
    end else if (push) begin
      wp_r <= wp_nxt;
      we_r <= we_nxt;
    end
  end

endmodule
`default_nettype wire

### design/spsm_queue.sv
// short word queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module spsm_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire spsm_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output spsm_pkg::entry_t      pop_entry,
  output logic                  empty
);

  localparam int QPTR_W = $clog2(spsm_pkg::QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(spsm_pkg::QUEUE_DEPTH + 1);

  spsm_pkg::entry_t   mem_r [spsm_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full      = (count_r == CNT_W'(spsm_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### design/spsm_back.sv
// back end: scale multiply, radix-2 restoring divide, result register
`timescale 1ns / 1ps
`default_nettype none
module spsm_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire spsm_pkg::cfg_t   cfg,
  input  wire logic             q_empty,
  input  wire spsm_pkg::entry_t pop_entry,
  output logic                  pop,
  spsm_out_if.source            out_ch
);

  localparam int REM_W = spsm_pkg::SAMPLE_W;

  spsm_pkg::back_state_t state_r, state_nxt;
  spsm_pkg::entry_t      entry_r, entry_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [spsm_pkg::QUOT_W-1:0]  bits_r, bits_nxt;
  logic [spsm_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [spsm_pkg::ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [spsm_pkg::IDX_W-1:0]   out_wi_r, out_wi_nxt;
  logic [spsm_pkg::IDX_W-1:0]   out_we_r, out_we_nxt;

  logic [REM_W-1:0]             span;
  logic [spsm_pkg::REG_W-1:0]   h_m2;
  logic [spsm_pkg::HMAG_W-1:0]  hmag;
  logic                         h_neg;
  logic [spsm_pkg::PROD_W-1:0]  prod;
  logic [spsm_pkg::NUM_W-1:0]   num;
  logic [REM_W:0]               trial;
  logic                         qbit;
  logic [spsm_pkg::ROW_W-1:0]   quot;
  logic [spsm_pkg::ROW_W-1:0]   row;
  logic                         out_free;

  assign span  = cfg.y_max - cfg.y_min;
  assign h_m2  = cfg.plot_height - spsm_pkg::REG_W'(2);
  // height of one gives a factor of minus one
  assign h_neg = (cfg.plot_height == spsm_pkg::REG_W'(1));
  assign hmag  = h_neg ? spsm_pkg::HMAG_W'(1) : spsm_pkg::HMAG_W'(h_m2);
  assign prod  = spsm_pkg::PROD_W'(entry_r.diff) * spsm_pkg::PROD_W'(hmag);
  assign num   = {prod, {spsm_pkg::FRAC_W{1'b0}}};

  assign trial = {rem_r, bits_r[spsm_pkg::QUOT_W-1]};
  assign qbit  = (trial >= {1'b0, span});
  assign quot  = spsm_pkg::ROW_W'(bits_r);

  always_comb begin
    case (entry_r.kind)
      spsm_pkg::KIND_DIVIDE: row = h_neg ? entry_r.row_q4 + quot : entry_r.row_q4 - quot;
      default:               row = entry_r.row_q4;
    endcase
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    rem_nxt       = rem_r;
    bits_nxt      = bits_r;
    step_nxt      = step_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_wi_nxt    = out_wi_r;
    out_we_nxt    = out_we_r;
    case (state_r)
      spsm_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          entry_nxt = pop_entry;
          state_nxt = (pop_entry.kind == spsm_pkg::KIND_DIVIDE) ?
                      spsm_pkg::B_MUL : spsm_pkg::B_DONE;
        end
      end
      spsm_pkg::B_MUL: begin
        // top bits of the product are already below the span
        rem_nxt   = num[spsm_pkg::NUM_W-1:spsm_pkg::QUOT_W];
        bits_nxt  = num[spsm_pkg::QUOT_W-1:0];
        step_nxt  = '0;
        state_nxt = spsm_pkg::B_DIV;
      end
      spsm_pkg::B_DIV: begin
        rem_nxt  = qbit ? REM_W'(trial - {1'b0, span}) : REM_W'(trial);
        bits_nxt = {bits_r[spsm_pkg::QUOT_W-2:0], qbit};
        step_nxt = step_r + spsm_pkg::STEP_W'(1);
        if (step_r == spsm_pkg::STEP_W'(spsm_pkg::QUOT_W - 1)) begin
          state_nxt = spsm_pkg::B_DONE;
        end
      end
      spsm_pkg::B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row;
          out_wi_nxt    = entry_r.write_index;
          out_we_nxt    = entry_r.window_end_index;
          state_nxt     = spsm_pkg::B_IDLE;
        end
      end
      default: state_nxt = spsm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spsm_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r   <= entry_nxt;
    rem_r     <= rem_nxt;
    bits_r    <= bits_nxt;
    step_r    <= step_nxt;
    out_row_r <= out_row_nxt;
    out_wi_r  <= out_wi_nxt;
    out_we_r  <= out_we_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.row_q4           = out_row_r;
  assign out_ch.write_index      = out_wi_r;
  assign out_ch.window_end_index = out_we_r;

endmodule
`default_nettype wire

### design/scrolling_plot_sample_mapper.sv
// top level of the scrolling plot sample mapper
// flow: clamped sample: pop, then load into the output register;
//   in-range sample: pop, multiply, 15 divide steps, then load
// pacing: the back end holds one word at a time and pops the next only after
//   the last is loaded; the 15-step radix-2 divider and a stalled output slow it
// reset: synchronous, active low; registers, ring pointers, queue and output valid are reset
`timescale 1ns / 1ps
`default_nettype none
module scrolling_plot_sample_mapper #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  spsm_in_if.sink                                in_ch,
  spsm_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [spsm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [spsm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [spsm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  // configuration registers
  spsm_pkg::cfg_t    cfg_r;
  spsm_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  // front to queue, queue to back
  logic              push;
  spsm_pkg::entry_t  push_entry;
  logic              q_full;
  logic              pop;
  spsm_pkg::entry_t  pop_entry;
  logic              q_empty;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  // registers sit on 4-byte steps
  assign reg_idx    = spsm_pkg::reg_idx_t'(cfg_paddr[spsm_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.y_min         <= spsm_pkg::Y_MIN_RST;
      cfg_r.y_max         <= spsm_pkg::Y_MAX_RST;
      cfg_r.top_row       <= '0;
      cfg_r.plot_height   <= '0;
      cfg_r.plot_width    <= '0;
      cfg_r.buffer_length <= spsm_pkg::BUF_LEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        spsm_pkg::REG_Y_MIN:         cfg_r.y_min         <= cfg_pwdata;
        spsm_pkg::REG_Y_MAX:         cfg_r.y_max         <= cfg_pwdata;
        spsm_pkg::REG_TOP_ROW:       cfg_r.top_row       <= cfg_pwdata[spsm_pkg::REG_W-1:0];
        spsm_pkg::REG_PLOT_HEIGHT:   cfg_r.plot_height   <= cfg_pwdata[spsm_pkg::REG_W-1:0];
        spsm_pkg::REG_PLOT_WIDTH:    cfg_r.plot_width    <= cfg_pwdata[spsm_pkg::REG_W-1:0];
        spsm_pkg::REG_BUFFER_LENGTH: cfg_r.buffer_length <= cfg_pwdata[spsm_pkg::REG_W-1:0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      spsm_pkg::REG_Y_MIN:         cfg_prdata = cfg_r.y_min;
      spsm_pkg::REG_Y_MAX:         cfg_prdata = cfg_r.y_max;
      spsm_pkg::REG_TOP_ROW:       cfg_prdata = spsm_pkg::CFG_DATA_W'(cfg_r.top_row);
      spsm_pkg::REG_PLOT_HEIGHT:   cfg_prdata = spsm_pkg::CFG_DATA_W'(cfg_r.plot_height);
      spsm_pkg::REG_PLOT_WIDTH:    cfg_prdata = spsm_pkg::CFG_DATA_W'(cfg_r.plot_width);
      spsm_pkg::REG_BUFFER_LENGTH: cfg_prdata = spsm_pkg::CFG_DATA_W'(cfg_r.buffer_length);
      default:                     cfg_prdata = '0;
    endcase
  end

  // front: accept, classify, ring pointers; disabled samples are dropped here
  spsm_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // two-entry queue so the front can take up to two words while the divider runs
  spsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // back: scale, divide and hold the result until the sink takes it
  spsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### design/spsm_checker.sv
// port-level checks of the scrolling plot sample mapper and their bind
`timescale 1ns / 1ps
`default_nettype none
module spsm_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [spsm_pkg::ROW_W-1:0]   out_row_q4,
  input wire logic [spsm_pkg::IDX_W-1:0]   out_write_index,
  input wire logic [spsm_pkg::IDX_W-1:0]   out_window_end_index
);

  localparam int PEND_W = 16;

  logic                        in_acc;
  logic                        out_acc;
  logic [PEND_W-1:0]           pend_r;
  logic                        seen_r;
  logic [spsm_pkg::IDX_W-1:0]  last_wi_r;
  logic [spsm_pkg::IDX_W-1:0]  last_we_r;
  logic [spsm_pkg::IDX_W-1:0]  wi_inc;
  logic [spsm_pkg::IDX_W-1:0]  we_inc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign wi_inc  = last_wi_r + spsm_pkg::IDX_W'(1);
  assign we_inc  = last_we_r + spsm_pkg::IDX_W'(1);

  // words taken but not yet delivered, sticky once saturated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
    end else begin
      if (pend_r != '1) begin
        pend_r <= pend_r + PEND_W'(in_acc) - PEND_W'(out_acc);
      end
      if (out_acc) begin
        seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_wi_r <= out_write_index;
      last_we_r <= out_window_end_index;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_q4)
      && $stable(out_write_index) && $stable(out_window_end_index))
    else $error("stalled output word changed");

  a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("output word without a matching input word");

  a_write_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r |-> (out_write_index == wi_inc) || (out_write_index == '0))
    else $error("write index did not advance by one or wrap");

  a_window_end_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r |->
      (out_window_end_index == we_inc) || (out_window_end_index == '0))
    else $error("window end index did not advance by one or wrap");

endmodule

bind scrolling_plot_sample_mapper spsm_checker u_spsm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_row_q4           (out_ch.row_q4),
  .out_write_index      (out_ch.write_index),
  .out_window_end_index (out_ch.window_end_index)
);
`default_nettype wire
